FILE: src/cle_pkg.sv
// ----------------------------------------------------------------------------
// cle_pkg
// Shared types, codes and opcode constants for the 8-bit load executor.
// ----------------------------------------------------------------------------
package cle_pkg;

  // Memory address width; every memory address is taken modulo 2**ADDR_BITS.
  localparam int ADDR_BITS = 16;
  localparam int MEM_DEPTH = 1 << ADDR_BITS;

  // Operand register codes as they appear in the opcode fields.
  typedef logic [2:0] reg_code_t;
  localparam reg_code_t REG_B      = 3'd0;
  localparam reg_code_t REG_C      = 3'd1;
  localparam reg_code_t REG_D      = 3'd2;
  localparam reg_code_t REG_E      = 3'd3;
  localparam reg_code_t REG_H      = 3'd4;
  localparam reg_code_t REG_L      = 3'd5;
  localparam reg_code_t REG_HL_MEM = 3'd6;
  localparam reg_code_t REG_A      = 3'd7;

  typedef enum logic [2:0] {
    ST_LOAD    = 3'd0,
    ST_NOP     = 3'd1,
    ST_STOP    = 3'd2,
    ST_UNIMP   = 3'd3,
    ST_UNKNOWN = 3'd4,
    ST_WRITTEN = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    SRC_REG,
    SRC_IMM,
    SRC_MEM
  } src_t;

  typedef enum logic [1:0] {
    AS_HL,
    AS_BC,
    AS_DE,
    AS_NN
  } asel_t;

  typedef enum logic [1:0] {
    DST_NONE,
    DST_REG,
    DST_MEM
  } dst_t;

  // Opcodes
  localparam logic [7:0] OP_NOP      = 8'h00;
  localparam logic [7:0] OP_STOP     = 8'h10;
  localparam logic [7:0] OP_HALT     = 8'h76;
  localparam logic [7:0] OP_LD_BC_A  = 8'h02;
  localparam logic [7:0] OP_LD_DE_A  = 8'h12;
  localparam logic [7:0] OP_LD_A_BC  = 8'h0A;
  localparam logic [7:0] OP_LD_A_DE  = 8'h1A;
  localparam logic [7:0] OP_LD_A_NN  = 8'hFA;
  localparam logic [7:0] OP_LD_NN_A  = 8'hEA;
  localparam logic [7:0] OP_LDI_HL_A = 8'h22;
  localparam logic [7:0] OP_LDI_A_HL = 8'h2A;
  localparam logic [7:0] OP_LDD_HL_A = 8'h32;
  localparam logic [7:0] OP_LDD_A_HL = 8'h3A;
  localparam logic [7:0] OP_LDH_N_A  = 8'hE0;
  localparam logic [7:0] OP_LDH_A_N  = 8'hF0;
  localparam logic [7:0] OP_LD_C_A   = 8'hE2;
  localparam logic [7:0] OP_LD_A_C   = 8'hF2;

  // Decoded instruction: where the byte comes from and where it goes.
  typedef struct packed {
    status_t   status;
    logic [1:0] len;
    logic      set_stop;
    src_t      src;
    reg_code_t src_reg;
    dst_t      dst;
    reg_code_t dst_reg;
    asel_t     asel;
  } dec_t;

  // A memory write transaction runs through the commit step as an
  // immediate byte stored at a direct address, with no PC advance.
  localparam dec_t DEC_WRITE = '{
    status:   ST_WRITTEN,
    len:      2'd0,
    set_stop: 1'b0,
    src:      SRC_IMM,
    src_reg:  REG_A,
    dst:      DST_MEM,
    dst_reg:  REG_A,
    asel:     AS_NN
  };

endpackage

FILE: src/cle_decode.sv
// ----------------------------------------------------------------------------
// cle_decode
// Opcode decoder for the 8-bit load subset.
// ----------------------------------------------------------------------------
module cle_decode (
  input  logic [7:0]     opcode,
  output cle_pkg::dec_t  dec
);

  always_comb begin
    dec = '{
      status:   cle_pkg::ST_UNKNOWN,
      len:      2'd1,
      set_stop: 1'b0,
      src:      cle_pkg::SRC_REG,
      src_reg:  cle_pkg::REG_A,
      dst:      cle_pkg::DST_NONE,
      dst_reg:  cle_pkg::REG_A,
      asel:     cle_pkg::AS_HL
    };
    if (opcode == cle_pkg::OP_NOP) begin
      dec.status = cle_pkg::ST_NOP;
    end else if (opcode == cle_pkg::OP_STOP) begin
      dec.status   = cle_pkg::ST_STOP;
      dec.len      = 2'd2;
      dec.set_stop = 1'b1;
    end else if (opcode[7:6] == 2'b01 && opcode != cle_pkg::OP_HALT) begin
      // Register to register, with (HL) standing in for code 6.
      dec.status  = cle_pkg::ST_LOAD;
      dec.src     = (opcode[2:0] == cle_pkg::REG_HL_MEM) ? cle_pkg::SRC_MEM
                                                         : cle_pkg::SRC_REG;
      dec.src_reg = opcode[2:0];
      dec.dst     = (opcode[5:3] == cle_pkg::REG_HL_MEM) ? cle_pkg::DST_MEM
                                                         : cle_pkg::DST_REG;
      dec.dst_reg = opcode[5:3];
    end else if (opcode[7:6] == 2'b00 && opcode[2:0] == cle_pkg::REG_HL_MEM) begin
      // Immediate load into a register or (HL).
      dec.status  = cle_pkg::ST_LOAD;
      dec.len     = 2'd2;
      dec.src     = cle_pkg::SRC_IMM;
      dec.dst     = (opcode[5:3] == cle_pkg::REG_HL_MEM) ? cle_pkg::DST_MEM
                                                         : cle_pkg::DST_REG;
      dec.dst_reg = opcode[5:3];
    end else if (opcode == cle_pkg::OP_LD_A_BC || opcode == cle_pkg::OP_LD_A_DE) begin
      dec.status = cle_pkg::ST_LOAD;
      dec.src    = cle_pkg::SRC_MEM;
      dec.asel   = (opcode == cle_pkg::OP_LD_A_BC) ? cle_pkg::AS_BC : cle_pkg::AS_DE;
      dec.dst    = cle_pkg::DST_REG;
    end else if (opcode == cle_pkg::OP_LD_BC_A || opcode == cle_pkg::OP_LD_DE_A) begin
      dec.status = cle_pkg::ST_LOAD;
      dec.asel   = (opcode == cle_pkg::OP_LD_BC_A) ? cle_pkg::AS_BC : cle_pkg::AS_DE;
      dec.dst    = cle_pkg::DST_MEM;
    end else if (opcode == cle_pkg::OP_LD_A_NN) begin
      dec.status = cle_pkg::ST_LOAD;
      dec.len    = 2'd3;
      dec.src    = cle_pkg::SRC_MEM;
      dec.asel   = cle_pkg::AS_NN;
      dec.dst    = cle_pkg::DST_REG;
    end else if (opcode == cle_pkg::OP_LD_NN_A) begin
      dec.status = cle_pkg::ST_LOAD;
      dec.len    = 2'd3;
      dec.asel   = cle_pkg::AS_NN;
      dec.dst    = cle_pkg::DST_MEM;
    end else if (opcode == cle_pkg::OP_LDI_HL_A || opcode == cle_pkg::OP_LDI_A_HL ||
                 opcode == cle_pkg::OP_LDD_HL_A || opcode == cle_pkg::OP_LDD_A_HL ||
                 opcode == cle_pkg::OP_LDH_N_A  || opcode == cle_pkg::OP_LDH_A_N  ||
                 opcode == cle_pkg::OP_LD_C_A   || opcode == cle_pkg::OP_LD_A_C) begin
      dec.status = cle_pkg::ST_UNIMP;
    end
  end

endmodule

FILE: src/cpu_8bit_load_executor.sv
// ----------------------------------------------------------------------------
// cpu_8bit_load_executor
// Executes the 8-bit load subset of a small 8-bit CPU out of a byte memory.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Transaction carries
//  --------+-----------+-------------------------------------------------------
//  in_     | input     | memory write (address, data) or one instruction step
//  out_    | output    | status, PC, registers A..L and stop flag after the step
//
// Flow: a memory write goes straight to commit, so writes stream at one per
// cycle while the output register is free or being emptied; an instruction passes
// fetch, decode, up to two operand reads and one data read before commit, all
// through one read port. Reset clears the sequencer, PC, registers, stop flag and
// output valid; byte memory is undefined until written and has no clearing pass.
// Stalls: the engine holds at commit only while the output register is full.
//
module cpu_8bit_load_executor (
  input  logic        clk,
  input  logic        rst_n,
  // Input transactions
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [15:0] address, [23:16] data
  input  logic        in_tuser,   // operation: 0 memory write, 1 execute
  // Result transactions
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // [15:0] pc_value, [23:16] reg_a, [31:24] reg_b,
                                  // [39:32] reg_c, [47:40] reg_d, [55:48] reg_e,
                                  // [63:56] reg_h, [71:64] reg_l, [72] stop_mode,
                                  // [79:73] zero
  output logic [2:0]  out_tuser   // status
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_DEC,
    S_OP1,
    S_OP2,
    S_MEMRD,
    S_FIN
  } state_t;

  // Sequencer state and per-instruction working registers.
  state_t            state_r, state_nxt;
  cle_pkg::dec_t     dec_r, dec_nxt;
  logic [7:0]        val_r, val_nxt;
  logic [7:0]        lo_r, lo_nxt;
  logic [15:0]       nn_r, nn_nxt;

  // Architectural state.
  logic [15:0]       pc_r, pc_nxt;
  logic [7:0]        regs_r [8];
  logic              stop_r, stop_nxt;

  // Output register. The payload other than status is read straight from the
  // architectural registers: they only change on a commit, and a commit only
  // happens when the output register is free or being emptied.
  logic              out_valid_r;
  cle_pkg::status_t  out_status_r;

  // Byte memory with one write port and one registered read port.
  logic [7:0]        mem [cle_pkg::MEM_DEPTH];
  logic              mem_re, mem_we;
  logic [15:0]       mem_raddr, mem_waddr;
  logic [7:0]        mem_rdata_r;

  cle_pkg::dec_t     dec_new;
  cle_pkg::asel_t    asel_use;
  logic [15:0]       ind_addr;
  logic [15:0]       pc1, pc2;
  logic [7:0]        wb_val;
  logic              out_free, commit, in_acc;

  cle_decode u_decode (
    .opcode (mem_rdata_r),
    .dec    (dec_new)
  );

  assign pc1 = pc_r + 16'd1;
  assign pc2 = pc_r + 16'd2;

  // Indirect address: during decode it follows the freshly decoded opcode,
  // at commit the latched one.
  assign asel_use = (state_r == S_DEC) ? dec_new.asel : dec_r.asel;

  always_comb begin
    case (asel_use)
      cle_pkg::AS_HL: ind_addr = {regs_r[cle_pkg::REG_H], regs_r[cle_pkg::REG_L]};
      cle_pkg::AS_BC: ind_addr = {regs_r[cle_pkg::REG_B], regs_r[cle_pkg::REG_C]};
      cle_pkg::AS_DE: ind_addr = {regs_r[cle_pkg::REG_D], regs_r[cle_pkg::REG_E]};
      cle_pkg::AS_NN: ind_addr = nn_r;
      default:        ind_addr = nn_r;
    endcase
  end

  assign out_free  = !out_valid_r || out_tready;
  assign commit    = (state_r == S_FIN) && out_free;
  // A new transaction is taken when the engine is empty, or in the very
  // cycle in which it commits the previous one.
  assign in_tready = (state_r == S_IDLE) || commit;
  assign in_acc    = in_tvalid && in_tready;

  // Sequencer: each state issues at most one memory read, whose data is
  // consumed by the following state.
  always_comb begin
    state_nxt = state_r;
    dec_nxt   = dec_r;
    val_nxt   = val_r;
    lo_nxt    = lo_r;
    nn_nxt    = nn_r;
    mem_re    = 1'b0;
    mem_raddr = pc_r;
    case (state_r)
      S_IDLE: begin
        state_nxt = S_IDLE;
      end
      S_FETCH: begin
        mem_re    = 1'b1;
        mem_raddr = pc_r;
        state_nxt = S_DEC;
      end
      S_DEC: begin
        dec_nxt = dec_new;
        if (dec_new.src == cle_pkg::SRC_IMM || dec_new.asel == cle_pkg::AS_NN) begin
          mem_re    = 1'b1;
          mem_raddr = pc1;
          state_nxt = S_OP1;
        end else if (dec_new.src == cle_pkg::SRC_MEM) begin
          mem_re    = 1'b1;
          mem_raddr = ind_addr;
          state_nxt = S_MEMRD;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_OP1: begin
        if (dec_r.asel == cle_pkg::AS_NN) begin
          lo_nxt    = mem_rdata_r;
          mem_re    = 1'b1;
          mem_raddr = pc2;
          state_nxt = S_OP2;
        end else begin
          val_nxt   = mem_rdata_r;
          state_nxt = S_FIN;
        end
      end
      S_OP2: begin
        // Direct address arrives low byte first.
        nn_nxt = {mem_rdata_r, lo_r};
        if (dec_r.src == cle_pkg::SRC_MEM) begin
          mem_re    = 1'b1;
          mem_raddr = {mem_rdata_r, lo_r};
          state_nxt = S_MEMRD;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_MEMRD: begin
        val_nxt   = mem_rdata_r;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (commit) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (in_acc) begin
      if (in_tuser) begin
        state_nxt = S_FETCH;
      end else begin
        state_nxt = S_FIN;
        dec_nxt   = cle_pkg::DEC_WRITE;
        val_nxt   = in_tdata[23:16];
        nn_nxt    = in_tdata[15:0];
      end
    end
  end

  // Commit: the loaded byte, if any, goes to a register or to memory; PC advances by the decoded length.
  assign wb_val    = (dec_r.src == cle_pkg::SRC_REG) ? regs_r[dec_r.src_reg] : val_r;
  assign mem_we    = commit && (dec_r.dst == cle_pkg::DST_MEM);
  assign mem_waddr = ind_addr;
  assign pc_nxt    = commit ? pc_r + {14'd0, dec_r.len} : pc_r;
  assign stop_nxt  = stop_r || (commit && dec_r.set_stop);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr[cle_pkg::ADDR_BITS-1:0]] <= wb_val;
    end
    if (mem_re) begin
      mem_rdata_r <= mem[mem_raddr[cle_pkg::ADDR_BITS-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      out_status_r <= cle_pkg::ST_LOAD;
      pc_r         <= 16'd0;
      stop_r       <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        regs_r[i] <= 8'd0;
      end
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
      stop_r  <= stop_nxt;
      if (commit && dec_r.dst == cle_pkg::DST_REG) begin
        regs_r[dec_r.dst_reg] <= wb_val;
      end
      if (commit) begin
        out_valid_r  <= 1'b1;
        out_status_r <= dec_r.status;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    dec_r <= dec_nxt;
    val_r <= val_nxt;
    lo_r  <= lo_nxt;
    nn_r  <= nn_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {7'd0, stop_r,
                       regs_r[cle_pkg::REG_L], regs_r[cle_pkg::REG_H],
                       regs_r[cle_pkg::REG_E], regs_r[cle_pkg::REG_D],
                       regs_r[cle_pkg::REG_C], regs_r[cle_pkg::REG_B],
                       regs_r[cle_pkg::REG_A], pc_r};

`ifndef NO_ASSERTIONS
  // The memory is never read and written in the same cycle.
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_re && mem_we))
    else $error("memory read and write in the same cycle");

  // A commit never overwrites a result that has not been taken.
  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    commit |-> (!out_valid_r || out_tready))
    else $error("commit while output register is full");

  // The program counter moves only on a commit.
  a_pc_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !commit |=> $stable(pc_r))
    else $error("program counter changed without a commit");

  // A result appears only after a commit.
  a_valid_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(commit))
    else $error("output valid without a commit");
`endif

endmodule
